// File: rtl/pcpal_pkg.sv
// ============================================================================
// pcpal_pkg
// Shared types, widths and codes for the closed polyline query block.
// ============================================================================
package pcpal_pkg;

  localparam int COORD_W = 32;            // signed Q16.16 coordinate
  localparam int DIFF_W  = COORD_W + 1;   // exact coordinate difference
  localparam int SQ_W    = 2 * DIFF_W;    // exact squared length, three terms
  localparam int NUM_W   = DIFF_W + SQ_W; // projection numerator
  localparam int ROOT_W  = DIFF_W;        // floor square root of a squared length
  localparam int ARC_W   = 32;            // unsigned Q16.16 distance
  localparam int KNOT_W  = 3 * COORD_W;   // one stored knot, x y z
  localparam int CNT_CFG_W = 7;

  localparam int MAX_KNOTS_DEFAULT = 64;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_CLOSEST = 2'd1;
  localparam logic [1:0] KIND_ARC     = 2'd2;
  localparam logic [1:0] KIND_DIST    = 2'd3;

  // Answer kinds.
  localparam logic [1:0] ANS_POINT = 2'd0;
  localparam logic [1:0] ANS_ARC   = 2'd1;
  localparam logic [1:0] ANS_DIST  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_KNOT_COUNT  = 1'b0;
  localparam logic REG_PATH_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]                kind;
    logic [5:0]                knot_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [ARC_W-1:0]          arc_in;
  } item_t;

  typedef struct packed {
    logic [1:0]                answer_kind;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [ARC_W-1:0]          out_arc;
  } result_t;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] knot_count;
    logic [ARC_W-1:0]     path_length;
  } cfg_t;

  // Magnitude of an exact difference; the most negative value maps to 2^32.
  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

endpackage

// File: rtl/pcpal_ram.sv
// ============================================================================
// pcpal_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module pcpal_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pcpal_div.sv
// ============================================================================
// pcpal_div
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ============================================================================
module pcpal_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcpal_pkg::NUM_W-1:0]   num,
  input  logic [pcpal_pkg::SQ_W-1:0]    den,
  output logic                          done,
  output logic [pcpal_pkg::DIFF_W-1:0]  quo,
  output logic [pcpal_pkg::SQ_W-1:0]    rem
);

  localparam int QW = pcpal_pkg::DIFF_W;
  localparam int RW = pcpal_pkg::SQ_W;

  logic            busy;
  logic [5:0]      cnt;
  logic [RW-1:0]   r;
  logic [RW-1:0]   den_r;
  logic [QW-1:0]   sh;
  logic [QW-1:0]   q;
  logic [RW:0]     trial;
  logic            fits;

  assign trial = {r, sh[QW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The high part of the numerator is below the divisor, so only the low
  // quotient bits are developed.
  always_ff @(posedge clk) begin
    if (start) begin
      r     <= num[pcpal_pkg::NUM_W-1:QW];
      sh    <= num[QW-1:0];
      den_r <= den;
      q     <= '0;
    end else if (busy) begin
      sh <= {sh[QW-2:0], 1'b0};
      if (fits) begin
        r <= RW'(trial - {1'b0, den_r});
        q <= {q[QW-2:0], 1'b1};
      end else begin
        r <= trial[RW-1:0];
        q <= {q[QW-2:0], 1'b0};
      end
    end
  end

  assign quo = q;
  assign rem = r;

endmodule

// File: rtl/pcpal_sqrt.sv
// ============================================================================
// pcpal_sqrt
// Integer floor square root, two radicand bits per cycle.
// ============================================================================
module pcpal_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcpal_pkg::SQ_W-1:0]    rad,
  output logic                          done,
  output logic [pcpal_pkg::ROOT_W-1:0]  root
);

  localparam int XW = pcpal_pkg::SQ_W;
  localparam int TW = pcpal_pkg::ROOT_W;
  localparam int MW = TW + 3;

  logic          busy;
  logic [5:0]    cnt;
  logic [XW-1:0] x;
  logic [MW-1:0] rm;
  logic [TW-1:0] rt;
  logic [MW-1:0] cand;
  logic [MW-1:0] trial;

  assign cand  = {rm[MW-3:0], x[XW-1:XW-2]};
  assign trial = {1'b0, rt, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(TW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x  <= rad;
      rm <= '0;
      rt <= '0;
    end else if (busy) begin
      x <= {x[XW-3:0], 2'b00};
      if (cand >= trial) begin
        rm <= cand - trial;
        rt <= {rt[TW-2:0], 1'b1};
      end else begin
        rm <= cand;
        rt <= {rt[TW-2:0], 1'b0};
      end
    end
  end

  assign root = rt;

endmodule

// File: rtl/pcpal_front.sv
// ============================================================================
// pcpal_front
// Input side: takes items, drops knot writes outside the store, and queues
// the rest for the sequencer in a two-entry queue.
// ============================================================================
module pcpal_front #(
  parameter int MAX_KNOTS = pcpal_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pcpal_pkg::item_t  item,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output pcpal_pkg::item_t  cmd
);

  pcpal_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;

  // A knot write to a slot beyond the store has no effect at all.
  assign keep = !(item.kind == pcpal_pkg::KIND_WRITE &&
                  32'(item.knot_index) >= 32'(MAX_KNOTS));

  assign item_stall = count == 2'd2;
  assign push       = item_valid && !item_stall && keep;
  assign cmd_valid  = count != 2'd0;
  assign pop        = cmd_pop && cmd_valid;
  assign cmd        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/pcpal_back.sv
// ============================================================================
// pcpal_back
// Sequencer that carries out queued items: knot writes, closest point, arc length
// and point at distance, with a shared multiplier, divider and square root.
// ============================================================================
module pcpal_back #(
  parameter int MAX_KNOTS = pcpal_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cmd_valid,
  output logic                                    cmd_pop,
  input  pcpal_pkg::item_t                        cmd,
  input  pcpal_pkg::cfg_t                         cfg,
  output logic                                    ram_we,
  output logic [(MAX_KNOTS > 1 ? $clog2(MAX_KNOTS) : 1)-1:0] ram_waddr,
  output logic [pcpal_pkg::KNOT_W-1:0]            ram_wdata,
  output logic [(MAX_KNOTS > 1 ? $clog2(MAX_KNOTS) : 1)-1:0] ram_raddr,
  input  logic [pcpal_pkg::KNOT_W-1:0]            ram_rdata,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output pcpal_pkg::result_t                      result
);

  localparam int IDX_W = MAX_KNOTS > 1 ? $clog2(MAX_KNOTS) : 1;
  localparam int CNT_W = $clog2(MAX_KNOTS + 1);
  localparam int CW    = pcpal_pkg::COORD_W;
  localparam int DW    = pcpal_pkg::DIFF_W;
  localparam int SW    = pcpal_pkg::SQ_W;
  localparam int NW    = pcpal_pkg::NUM_W;
  localparam int RTW   = pcpal_pkg::ROOT_W;
  localparam int AW    = pcpal_pkg::ARC_W;
  localparam int TOT_W = RTW + CNT_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MOD_W  = 5'd1;
  localparam logic [4:0] S_RDA    = 5'd2;
  localparam logic [4:0] S_RDB    = 5'd3;
  localparam logic [4:0] S_GETB   = 5'd4;
  localparam logic [4:0] S_DIFF   = 5'd5;
  localparam logic [4:0] S_SEG2   = 5'd6;
  localparam logic [4:0] S_DOT    = 5'd7;
  localparam logic [4:0] S_CLAMP  = 5'd8;
  localparam logic [4:0] S_PM_LO  = 5'd9;
  localparam logic [4:0] S_PM_HI  = 5'd10;
  localparam logic [4:0] S_PM_SUM = 5'd11;
  localparam logic [4:0] S_PDIV   = 5'd12;
  localparam logic [4:0] S_PT     = 5'd13;
  localparam logic [4:0] S_SQD    = 5'd14;
  localparam logic [4:0] S_CMP    = 5'd15;
  localparam logic [4:0] S_SQS    = 5'd16;
  localparam logic [4:0] S_ARC_GO = 5'd17;
  localparam logic [4:0] S_ARC_W  = 5'd18;
  localparam logic [4:0] S_LEN_GO = 5'd19;
  localparam logic [4:0] S_LEN_W  = 5'd20;
  localparam logic [4:0] S_NEXT   = 5'd21;
  localparam logic [4:0] S_DONE   = 5'd22;

  logic [4:0]       state;
  logic [1:0]       c;
  logic [1:0]       pc;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] n;
  logic [1:0]       op;

  logic signed [CW-1:0] qp   [3];
  logic signed [CW-1:0] ka   [3];
  logic signed [CW-1:0] kb   [3];
  logic signed [CW-1:0] pv   [3];
  logic signed [CW-1:0] bestp[3];
  logic signed [DW-1:0] seg  [3];
  logic signed [DW-1:0] df   [3];
  logic signed [DW-1:0] dv   [3];
  logic signed [DW-1:0] sv   [3];

  logic [SW-1:0]    seg2;
  logic [SW-1:0]    pos;
  logic [SW-1:0]    neg;
  logic [SW-1:0]    d2;
  logic [SW-1:0]    best_d2;
  logic [SW-1:0]    s2;
  logic [SW-1:0]    pnum;
  logic [SW-1:0]    pden;
  logic [SW-1:0]    plo;
  logic [SW-1:0]    mul_p;
  logic             mul_neg;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] best_arc;
  logic [AW-1:0]    dwrap;

  logic [DW-1:0]    mul_a;
  logic [DW-1:0]    mul_b;
  logic             mul_sgn;
  logic [SW-1:0]    dot;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] i_next;
  logic             idle_query;

  logic             div_start;
  logic [NW-1:0]    div_num;
  logic [SW-1:0]    div_den;
  logic             div_done;
  logic [DW-1:0]    div_quo;
  logic [SW-1:0]    div_rem;
  logic             sq_start;
  logic [SW-1:0]    sq_rad;
  logic             sq_done;
  logic [RTW-1:0]   sq_root;

  logic signed [DW:0] poff;
  logic signed [DW:0] psum;
  logic [TOT_W-1:0]   tot_len;

  assign used = (32'(cfg.knot_count) > 32'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS)
                                                        : CNT_W'(cfg.knot_count);
  assign i_next     = (CNT_W'(i + 1'b1) == n) ? '0 : CNT_W'(i + 1'b1);
  assign idle_query = state == S_IDLE && cmd_valid && cmd.kind != pcpal_pkg::KIND_WRITE;
  assign dot        = pos - neg;
  assign tot_len    = total + TOT_W'(sq_root);

  // Knot writes and queue pops.
  assign cmd_pop   = state == S_IDLE && cmd_valid;
  assign ram_we    = cmd_pop && cmd.kind == pcpal_pkg::KIND_WRITE;
  assign ram_waddr = IDX_W'(cmd.knot_index);
  assign ram_wdata = {cmd.coord_x, cmd.coord_y, cmd.coord_z};
  assign ram_raddr = (state == S_RDB) ? i_next[IDX_W-1:0] : i[IDX_W-1:0];

  // Shared multiplier operand selection.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sgn = 1'b0;
    case (state)
      S_SEG2: begin
        if (c != 2'd3) begin
          mul_a = pcpal_pkg::mag(seg[c]);
          mul_b = mul_a;
        end
      end
      S_DOT: begin
        if (c != 2'd3) begin
          mul_a   = pcpal_pkg::mag(df[c]);
          mul_b   = pcpal_pkg::mag(seg[c]);
          mul_sgn = df[c][DW-1] != seg[c][DW-1];
        end
      end
      S_SQD: begin
        if (c != 2'd3) begin
          mul_a = pcpal_pkg::mag(dv[c]);
          mul_b = mul_a;
        end
      end
      S_SQS: begin
        if (c != 2'd3) begin
          mul_a = pcpal_pkg::mag(sv[c]);
          mul_b = mul_a;
        end
      end
      S_PM_LO: begin
        if (pc != 2'd3) begin
          mul_a = pcpal_pkg::mag(seg[pc]);
        end
        mul_b = pnum[DW-1:0];
      end
      S_PM_HI: begin
        if (pc != 2'd3) begin
          mul_a = pcpal_pkg::mag(seg[pc]);
        end
        mul_b = pnum[SW-1:DW];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p   <= mul_a * mul_b;
    mul_neg <= mul_sgn;
  end

  // Divider: path wrap at the start of a distance query, then projections.
  assign div_start = (idle_query && cmd.kind == pcpal_pkg::KIND_DIST && used != '0 &&
                      cfg.path_length != '0) || state == S_PM_SUM;
  assign div_num   = (state == S_PM_SUM) ? ({{DW{1'b0}}, plo} + {mul_p, {DW{1'b0}}})
                                         : NW'(cmd.arc_in);
  assign div_den   = (state == S_PM_SUM) ? pden : SW'(cfg.path_length);

  assign sq_start = state == S_ARC_GO || state == S_LEN_GO;
  assign sq_rad   = (state == S_ARC_GO) ? s2 : seg2;

  pcpal_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  pcpal_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Start knot plus the signed share of the segment for one component.
  always_comb begin
    poff = '0;
    psum = '0;
    if (pc != 2'd3) begin
      poff = seg[pc][DW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      psum = $signed({{2{ka[pc][CW-1]}}, ka[pc]}) + poff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      c            <= '0;
      pc           <= '0;
      i            <= '0;
      n            <= '0;
      op           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (idle_query) begin
            op       <= cmd.kind;
            qp[0]    <= cmd.coord_x;
            qp[1]    <= cmd.coord_y;
            qp[2]    <= cmd.coord_z;
            i        <= '0;
            n        <= used;
            total    <= '0;
            best_arc <= '0;
            dwrap    <= cmd.arc_in;
            for (int k = 0; k < 3; k++) begin
              pv[k]    <= '0;
              bestp[k] <= '0;
            end
            if (used == '0) begin
              state <= S_DONE;
            end else if (cmd.kind == pcpal_pkg::KIND_DIST && cfg.path_length != '0) begin
              state <= S_MOD_W;
            end else begin
              state <= S_RDA;
            end
          end
        end
        S_MOD_W: begin
          if (div_done) begin
            dwrap <= div_rem[AW-1:0];
            state <= S_RDA;
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          ka[0] <= ram_rdata[3*CW-1:2*CW];
          ka[1] <= ram_rdata[2*CW-1:CW];
          ka[2] <= ram_rdata[CW-1:0];
          state <= S_GETB;
        end
        S_GETB: begin
          kb[0] <= ram_rdata[3*CW-1:2*CW];
          kb[1] <= ram_rdata[2*CW-1:CW];
          kb[2] <= ram_rdata[CW-1:0];
          state <= S_DIFF;
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            seg[k] <= {kb[k][CW-1], kb[k]} - {ka[k][CW-1], ka[k]};
            df[k]  <= {qp[k][CW-1], qp[k]} - {ka[k][CW-1], ka[k]};
          end
          c     <= '0;
          state <= S_SEG2;
        end
        S_SEG2: begin
          if (c != 2'd0) begin
            seg2 <= (c == 2'd1) ? mul_p : seg2 + mul_p;
          end
          if (c == 2'd3) begin
            c     <= '0;
            state <= (op == pcpal_pkg::KIND_DIST) ? S_LEN_GO : S_DOT;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_DOT: begin
          if (c == 2'd1) begin
            pos <= mul_neg ? '0 : mul_p;
            neg <= mul_neg ? mul_p : '0;
          end else if (c != 2'd0) begin
            if (mul_neg) begin
              neg <= neg + mul_p;
            end else begin
              pos <= pos + mul_p;
            end
          end
          if (c == 2'd3) begin
            c     <= '0;
            state <= S_CLAMP;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_CLAMP: begin
          // Zero-length segment or projection behind the start: start knot.
          if (seg2 == '0 || pos <= neg) begin
            pv    <= ka;
            state <= S_PT;
          end else if (dot >= seg2) begin
            pv    <= kb;
            state <= S_PT;
          end else begin
            pnum  <= dot;
            pden  <= seg2;
            pc    <= '0;
            state <= S_PM_LO;
          end
        end
        S_PM_LO: begin
          state <= S_PM_HI;
        end
        S_PM_HI: begin
          plo   <= mul_p;
          state <= S_PM_SUM;
        end
        S_PM_SUM: begin
          state <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            if (pc != 2'd3) begin
              pv[pc] <= psum[CW-1:0];
            end
            if (pc == 2'd2) begin
              state <= (op == pcpal_pkg::KIND_DIST) ? S_DONE : S_PT;
            end else begin
              pc    <= pc + 2'd1;
              state <= S_PM_LO;
            end
          end
        end
        S_PT: begin
          for (int k = 0; k < 3; k++) begin
            dv[k] <= {qp[k][CW-1], qp[k]} - {pv[k][CW-1], pv[k]};
            sv[k] <= {pv[k][CW-1], pv[k]} - {ka[k][CW-1], ka[k]};
          end
          c     <= '0;
          state <= S_SQD;
        end
        S_SQD: begin
          if (c != 2'd0) begin
            d2 <= (c == 2'd1) ? mul_p : d2 + mul_p;
          end
          if (c == 2'd3) begin
            c     <= '0;
            state <= S_CMP;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_CMP: begin
          // The first segment always wins; later ones only when strictly nearer.
          if (i == '0 || d2 < best_d2) begin
            best_d2 <= d2;
            bestp   <= pv;
            c       <= '0;
            state   <= S_SQS;
          end else begin
            state <= S_LEN_GO;
          end
        end
        S_SQS: begin
          if (c != 2'd0) begin
            s2 <= (c == 2'd1) ? mul_p : s2 + mul_p;
          end
          if (c == 2'd3) begin
            c     <= '0;
            state <= S_ARC_GO;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_ARC_GO: begin
          state <= S_ARC_W;
        end
        S_ARC_W: begin
          if (sq_done) begin
            best_arc <= tot_len;
            state    <= S_LEN_GO;
          end
        end
        S_LEN_GO: begin
          state <= S_LEN_W;
        end
        S_LEN_W: begin
          if (sq_done) begin
            if (op == pcpal_pkg::KIND_DIST && tot_len > TOT_W'(dwrap)) begin
              pnum  <= SW'(TOT_W'(dwrap) - total);
              pden  <= SW'(sq_root);
              pc    <= '0;
              state <= S_PM_LO;
            end else begin
              total <= tot_len;
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (CNT_W'(i + 1'b1) == n) begin
            state <= S_DONE;
          end else begin
            i     <= CNT_W'(i + 1'b1);
            state <= S_RDA;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid       <= 1'b1;
            result.answer_kind <= op - 2'd1;
            result.out_x       <= '0;
            result.out_y       <= '0;
            result.out_z       <= '0;
            result.out_arc     <= '0;
            case (op)
              pcpal_pkg::KIND_CLOSEST: begin
                result.out_x <= bestp[0];
                result.out_y <= bestp[1];
                result.out_z <= bestp[2];
              end
              pcpal_pkg::KIND_ARC: begin
                result.out_arc <= (best_arc > TOT_W'({AW{1'b1}})) ? {AW{1'b1}}
                                                                 : best_arc[AW-1:0];
              end
              pcpal_pkg::KIND_DIST: begin
                result.out_x <= pv[0];
                result.out_y <= pv[1];
                result.out_z <= pv[2];
              end
              default: begin
                result.out_arc <= '0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/polyline_closest_point_arc_length.sv
// ============================================================================
// polyline_closest_point_arc_length
// Closest point, arc length and point at distance on a stored closed polyline.
// ============================================================================
// The block holds up to MAX_KNOTS knots of a closed 3D path in signed Q16.16
// and answers one item at a time. A closest point or arc length query walks
// every segment of the path; per segment it uses the shared 33-step divider
// (three projection divisions, only when the projection falls inside the
// segment) and the 33-step square root (segment length, plus the arc offset
// when the segment becomes the nearest). A point at distance query wraps the
// distance modulo path_length when that is nonzero, walks segments until the
// summed length passes the wrapped distance, and then interpolates in that
// segment. A front queue of two items accepts new transfers while the
// sequencer works, and a finished result waits in the output register while
// the sequencer goes on with its next item, which can only be delivered once
// that register is free. Knot slots at or above MAX_KNOTS are dropped on
// input, and knot_count above MAX_KNOTS is treated as MAX_KNOTS.
// Configuration must be written through cfg_wr_en, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
// ============================================================================
module polyline_closest_point_arc_length #(
  parameter int MAX_KNOTS = pcpal_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  pcpal_pkg::item_t             item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output pcpal_pkg::result_t           result,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [pcpal_pkg::ARC_W-1:0]  cfg_data
);

  localparam int IDX_W = MAX_KNOTS > 1 ? $clog2(MAX_KNOTS) : 1;

  pcpal_pkg::cfg_t  cfg;
  pcpal_pkg::item_t cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [pcpal_pkg::KNOT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]               ram_raddr;
  logic [pcpal_pkg::KNOT_W-1:0]   ram_rdata;

  // Configuration registers; a write lands at the clock edge it is presented.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pcpal_pkg::REG_KNOT_COUNT: begin
          cfg.knot_count <= cfg_data[pcpal_pkg::CNT_CFG_W-1:0];
        end
        pcpal_pkg::REG_PATH_LENGTH: begin
          cfg.path_length <= cfg_data;
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Front: input transfers, classification and the two-item queue.
  pcpal_front #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd)
  );

  // Knot store, one entry holds x, y and z.
  pcpal_ram #(
    .WIDTH (pcpal_pkg::KNOT_W),
    .DEPTH (MAX_KNOTS)
  ) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: the segment walking sequencer and the result register.
  pcpal_back #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .cfg          (cfg),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // An arc length answer never carries a point.
  a_arc_no_point : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.answer_kind == pcpal_pkg::ANS_ARC |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
    else $error("arc length answer carries a nonzero point");

  // Point answers never carry an arc length.
  a_point_no_arc : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.answer_kind != pcpal_pkg::ANS_ARC |-> result.out_arc == '0)
    else $error("point answer carries a nonzero arc length");

  // Only the three answer kinds ever leave the block.
  a_answer_kind : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.answer_kind == pcpal_pkg::ANS_POINT ||
                     result.answer_kind == pcpal_pkg::ANS_ARC ||
                     result.answer_kind == pcpal_pkg::ANS_DIST)
    else $error("result transfer with an undefined answer kind");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Closed polyline query block testbench
// Loads knot sets, issues closest point, arc length and point at distance
// queries, and compares every result against an in-bench predictor.
// ============================================================================
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pcpal_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pcpal_pkg::result_t result;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = pcpal_pkg::REG_KNOT_COUNT;
  logic [pcpal_pkg::ARC_W-1:0] cfg_data = '0;

  polyline_closest_point_arc_length DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: a shadow of the knot store and the two registers.
  logic signed [31:0] shadow_x [64];
  logic signed [31:0] shadow_y [64];
  logic signed [31:0] shadow_z [64];
  logic [6:0] shadow_count;
  logic [31:0] shadow_path;

  pcpal_pkg::result_t pending_answers[$];
  int errors = 0;
  longint cycles = 0;
  bit idle_off = 1'b0;

  // Stops a stuck run; the slowest query walks 64 segments.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd40000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Exact integer square root, floor, of a value below 2^100.
  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 50; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] sq_len(input longint dx, input longint dy,
                                          input longint dz);
    logic [127:0] ax, ay, az;
    ax = 128'(dx < 0 ? -dx : dx);
    ay = 128'(dy < 0 ? -dy : dy);
    az = 128'(dz < 0 ? -dz : dz);
    return ax * ax + ay * ay + az * az;
  endfunction

  // sign(s) * floor(|s| * num / den), truncated toward zero.
  function automatic longint scaled_part(input longint s, input logic [127:0] num,
                                         input logic [127:0] den);
    logic [127:0] m;
    m = (128'(s < 0 ? -s : s) * num) / den;
    return s < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Clamped projection of query q onto segment a..b.
  task automatic project_onto(input longint q[3], input longint a[3], input longint b[3],
                              output longint p[3]);
    longint seg[3];
    logic signed [129:0] dot;
    logic [127:0] seg2;
    for (int c = 0; c < 3; c++) seg[c] = b[c] - a[c];
    seg2 = sq_len(seg[0], seg[1], seg[2]);
    dot = '0;
    for (int c = 0; c < 3; c++) dot += 130'(signed'(q[c] - a[c])) * 130'(signed'(seg[c]));
    p = a;
    if (seg2 == 0 || dot <= 0) return;
    if (dot >= signed'({2'b0, seg2})) begin
      p = b;
      return;
    end
    for (int c = 0; c < 3; c++) p[c] = a[c] + scaled_part(seg[c], 128'(dot), seg2);
  endtask

  task automatic knot_at(input int i, output longint k[3]);
    k[0] = shadow_x[i];
    k[1] = shadow_y[i];
    k[2] = shadow_z[i];
  endtask

  // Computes the answer the block should give for one query item.
  task automatic predict_query(input pcpal_pkg::item_t it, output pcpal_pkg::result_t ans);
    int n;
    longint q[3], pt[3], a[3], b[3], p[3];
    logic [127:0] best_d2, d2;
    logic [63:0] total, arc, wrapped, len, prev;
    n = shadow_count > 64 ? 64 : shadow_count;
    q[0] = it.coord_x;
    q[1] = it.coord_y;
    q[2] = it.coord_z;
    pt = '{0, 0, 0};
    arc = 0;
    total = 0;
    best_d2 = 0;
    if (n != 0 && it.kind != pcpal_pkg::KIND_DIST) begin
      for (int i = 0; i < n; i++) begin
        knot_at(i, a);
        knot_at((i + 1) % n, b);
        project_onto(q, a, b, p);
        d2 = sq_len(q[0] - p[0], q[1] - p[1], q[2] - p[2]);
        if (i == 0 || d2 < best_d2) begin
          best_d2 = d2;
          pt = p;
          arc = total + isqrt(sq_len(p[0] - a[0], p[1] - a[1], p[2] - a[2]));
        end
        total += isqrt(sq_len(b[0] - a[0], b[1] - a[1], b[2] - a[2]));
      end
    end else if (n != 0) begin
      wrapped = shadow_path == 0 ? 64'(it.arc_in) : 64'(it.arc_in % shadow_path);
      for (int i = 0; i < n; i++) begin
        knot_at(i, a);
        knot_at((i + 1) % n, b);
        len = isqrt(sq_len(b[0] - a[0], b[1] - a[1], b[2] - a[2]));
        prev = total;
        total += len;
        if (total > wrapped) begin
          for (int c = 0; c < 3; c++)
            pt[c] = a[c] + scaled_part(b[c] - a[c], 128'(wrapped - prev), 128'(len));
          break;
        end
      end
    end
    ans.answer_kind = it.kind - 2'd1;
    ans.out_x = it.kind == pcpal_pkg::KIND_ARC ? '0 : pt[0][31:0];
    ans.out_y = it.kind == pcpal_pkg::KIND_ARC ? '0 : pt[1][31:0];
    ans.out_z = it.kind == pcpal_pkg::KIND_ARC ? '0 : pt[2][31:0];
    ans.out_arc = it.kind != pcpal_pkg::KIND_ARC ? '0 :
                  (arc > 64'hFFFF_FFFF ? '1 : arc[31:0]);
  endtask

  // Sends one item, at times after a random hold-off, and updates the predictor.
  // Valid stays high after the transfer so that the next item can follow at
  // once; a hold-off or a drain lowers it.
  task automatic send_item(input pcpal_pkg::item_t it);
    pcpal_pkg::result_t ans;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.kind == pcpal_pkg::KIND_WRITE) begin
      shadow_x[it.knot_index] = it.coord_x;
      shadow_y[it.knot_index] = it.coord_y;
      shadow_z[it.knot_index] = it.coord_z;
    end else begin
      predict_query(it, ans);
      pending_answers = {pending_answers, ans};
    end
  endtask

  // Receiver: random stall bursts, and a field-by-field compare per transfer.
  always @(posedge clk) begin
    pcpal_pkg::result_t exp_ans;
    if (!rst && result_valid && !result_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (result.answer_kind !== exp_ans.answer_kind || result.out_x !== exp_ans.out_x ||
            result.out_y !== exp_ans.out_y || result.out_z !== exp_ans.out_z ||
            result.out_arc !== exp_ans.out_arc) begin
          $display("%0t mismatch: expected %h actual %h", $time, exp_ans, result);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == pcpal_pkg::REG_KNOT_COUNT) shadow_count = val[6:0];
    else shadow_path = val;
  endtask

  function automatic pcpal_pkg::item_t make_item(input logic [1:0] k, input int idx,
                                                 input logic [31:0] x, input logic [31:0] y,
                                                 input logic [31:0] z, input logic [31:0] d);
    pcpal_pkg::item_t it;
    it.kind = k;
    it.knot_index = 6'(idx);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.arc_in = d;
    return it;
  endfunction

  // A coordinate that is mostly modest in size, sometimes full range.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return 32'(signed'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  task automatic random_query();
    logic [1:0] k;
    k = 2'($urandom_range(1, 3));
    send_item(make_item(k, $urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord(),
                        $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0200_0000)));
  endtask

  task automatic load_knots(input int n, input bit wide);
    for (int i = 0; i < n; i++)
      send_item(make_item(pcpal_pkg::KIND_WRITE, i, wide ? $urandom() : rand_coord(),
                          wide ? $urandom() : rand_coord(), wide ? $urandom() : rand_coord(), 0));
  endtask

  // Empty path, extreme coordinates and the special geometric cases.
  task automatic test_directed();
    send_item(make_item(pcpal_pkg::KIND_CLOSEST, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    send_item(make_item(pcpal_pkg::KIND_ARC, 0, 0, 0, 0, 0));
    send_item(make_item(pcpal_pkg::KIND_DIST, 0, 0, 0, 0, 32'hFFFF_FFFF));
    wait_drained();
    // Two distinct knots plus one repeated knot gives a zero-length segment.
    send_item(make_item(pcpal_pkg::KIND_WRITE, 0, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 0));
    send_item(make_item(pcpal_pkg::KIND_WRITE, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 0));
    send_item(make_item(pcpal_pkg::KIND_WRITE, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 0));
    send_item(make_item(pcpal_pkg::KIND_WRITE, 63, 32'h0001_0000, 0, 0, 0));
    wait_drained();
    write_reg(pcpal_pkg::REG_KNOT_COUNT, 3);
    write_reg(pcpal_pkg::REG_PATH_LENGTH, 0);
    send_item(make_item(pcpal_pkg::KIND_CLOSEST, 0, 0, 0, 0, 0));
    send_item(make_item(pcpal_pkg::KIND_CLOSEST, 0, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 0));
    send_item(make_item(pcpal_pkg::KIND_ARC, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 0));
    send_item(make_item(pcpal_pkg::KIND_ARC, 0, 32'h0000_1000, 32'hFFFF_0000, 0, 0));
    send_item(make_item(pcpal_pkg::KIND_DIST, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(make_item(pcpal_pkg::KIND_DIST, 0, 0, 0, 0, 0));
    wait_drained();
    write_reg(pcpal_pkg::REG_PATH_LENGTH, 32'hFFFF_FFFF);
    send_item(make_item(pcpal_pkg::KIND_DIST, 0, 0, 0, 0, 32'hFFFF_FFFE));
    send_item(make_item(pcpal_pkg::KIND_DIST, 0, 0, 0, 0, 32'h1234_5678));
    wait_drained();
    write_reg(pcpal_pkg::REG_KNOT_COUNT, 1);
    send_item(make_item(pcpal_pkg::KIND_CLOSEST, 0, 5, 6, 7, 0));
    send_item(make_item(pcpal_pkg::KIND_DIST, 0, 0, 0, 0, 9));
    wait_drained();
  endtask

  // Random knot sets of varied size and random queries against each.
  task automatic test_random_paths();
    int n;
    for (int phase = 0; phase < 12; phase++) begin
      n = phase == 5 ? 64 : $urandom_range(2, 8);
      load_knots(n, phase % 4 == 3);
      wait_drained();
      write_reg(pcpal_pkg::REG_KNOT_COUNT, phase == 6 ? 32'd127 : 32'(n));
      if (phase == 6) n = 64;
      write_reg(pcpal_pkg::REG_PATH_LENGTH,
                phase % 3 == 0 ? 32'd0 : $urandom_range(1, 32'h0400_0000));
      for (int j = 0; j < (n == 64 ? 4 : 14); j++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(make_item(pcpal_pkg::KIND_WRITE, $urandom_range(0, n - 1),
                              rand_coord(), rand_coord(), rand_coord(), $urandom()));
        else random_query();
      end
      wait_drained();
    end
  endtask

  // Last part: no idling on either side, back-to-back transfers.
  task automatic test_full_rate();
    idle_off = 1'b1;
    for (int j = 0; j < 25; j++) random_query();
    wait_drained();
  endtask

  initial begin
    shadow_count = 0;
    shadow_path = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_paths();
    test_full_rate();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pcpal_pkg.sv
rtl/pcpal_ram.sv
rtl/pcpal_div.sv
rtl/pcpal_sqrt.sv
rtl/pcpal_front.sv
rtl/pcpal_back.sv
rtl/polyline_closest_point_arc_length.sv
sim/testbench.sv
